FILE: rtl/core/swas_pkg.sv
`timescale 1ns / 1ps

package swas_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [2:0] REQ_OPEN    = 3'd0;
	localparam logic [2:0] REQ_SEND    = 3'd1;
	localparam logic [2:0] REQ_RECV    = 3'd2;
	localparam logic [2:0] REQ_TIMEOUT = 3'd3;
	localparam logic [2:0] REQ_CLOSE   = 3'd4;

	// Packet flag bits.
	localparam logic [3:0] FLG_SYN  = 4'h1;
	localparam logic [3:0] FLG_ACK  = 4'h2;
	localparam logic [3:0] FLG_FIN  = 4'h4;
	localparam logic [3:0] FLG_DATA = 4'h8;

	// Result status codes.
	localparam logic [2:0] ST_NEW       = 3'd0;
	localparam logic [2:0] ST_RESENT    = 3'd1;
	localparam logic [2:0] ST_DROPPED   = 3'd2;
	localparam logic [2:0] ST_CONNECTED = 3'd3;
	localparam logic [2:0] ST_ACKED     = 3'd4;
	localparam logic [2:0] ST_CLOSED    = 3'd5;
	localparam logic [2:0] ST_GAVEUP    = 3'd6;
	localparam logic [2:0] ST_REJECTED  = 3'd7;

	// Encoded link phase as reported on the output.
	localparam logic [2:0] LP_IDLE   = 3'd0;
	localparam logic [2:0] LP_SYNW   = 3'd1;
	localparam logic [2:0] LP_EST    = 3'd2;
	localparam logic [2:0] LP_DATAW  = 3'd3;
	localparam logic [2:0] LP_FINW   = 3'd4;
	localparam logic [2:0] LP_CLOSED = 3'd5;
	localparam logic [2:0] LP_FAILED = 3'd6;

	localparam logic [3:0] RETRY_LIMIT_RESET = 4'd5;

	localparam int IN_DATA_W  = 72;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 4;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_SYNW   = 7'b0000010,
		PH_EST    = 7'b0000100,
		PH_DATAW  = 7'b0001000,
		PH_FINW   = 7'b0010000,
		PH_CLOSED = 7'b0100000,
		PH_FAILED = 7'b1000000
	} phase_t;

	function automatic logic [2:0] phase_code(input phase_t ph);
		logic [2:0] code;
		code = LP_IDLE;
		unique case (ph)
			PH_IDLE:   code = LP_IDLE;
			PH_SYNW:   code = LP_SYNW;
			PH_EST:    code = LP_EST;
			PH_DATAW:  code = LP_DATAW;
			PH_FINW:   code = LP_FINW;
			PH_CLOSED: code = LP_CLOSED;
			PH_FAILED: code = LP_FAILED;
			default:   code = LP_IDLE;
		endcase
		return code;
	endfunction

	// Inverted 16-bit sum of five header bytes. Five bytes never carry
	// past bit 10, so the end-around fold is always empty.
	function automatic logic [15:0] hdr_csum(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c, input logic [7:0] d, input logic [7:0] e);
		logic [10:0] s;
		s = {3'd0, a} + {3'd0, b} + {3'd0, c} + {3'd0, d} + {3'd0, e};
		return ~{5'd0, s};
	endfunction

endpackage

FILE: rtl/core/stop_and_wait_sender.sv
`timescale 1ns / 1ps
// Stop-and-wait link sender: one request word in, one result word out.
// The accepted request sits in the input register, then the event logic feeds
// the result register. The link state is updated in a single pass.
// Throughput: one word per cycle while the downstream side keeps taking results.
// Reset (arst_n low, asynchronous): phase idle, counters and pending packet
// cleared, the retry limit back to 5, both pipeline stages empty.
module stop_and_wait_sender (
	input  logic                                clk,
	input  logic                                arst_n,
	// Retry limit register.
	input  logic                                cfg_we,
	input  logic [3:0]                          cfg_wdata,
	// Request stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [7:0] data_byte, [15:8] rx_seq, [23:16] rx_ack_num, [31:24] rx_flags,
	// [39:32] rx_len, [47:40] rx_data, [63:48] rx_checksum, [64] rx_frame_ok, rest zero
	input  logic [swas_pkg::IN_DATA_W-1:0]      s_tdata,
	// [2:0] req_type
	input  logic [swas_pkg::IN_USER_W-1:0]      s_tuser,
	// Result stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [7:0] tx_seq, [15:8] tx_ack_num, [19:16] tx_flags, [20] tx_len,
	// [28:21] tx_data, [44:29] tx_checksum, [47:45] link_phase
	output logic [swas_pkg::OUT_DATA_W-1:0]     m_tdata,
	// [0] send_valid, [3:1] status
	output logic [swas_pkg::OUT_USER_W-1:0]     m_tuser
);
	import swas_pkg::*;

	// Stage 1 holds the accepted request word; the result register holds the
	// finished result until the downstream side takes it.
	logic                   valid_s1;
	logic [IN_DATA_W-1:0]   data_s1;
	logic [IN_USER_W-1:0]   user_s1;
	logic                   out_valid_q;
	logic [OUT_DATA_W-1:0]  out_data_q;
	logic [OUT_USER_W-1:0]  out_user_q;

	// The result register can take a new word when it is empty or being drained.
	logic advance;
	logic fire;
	assign advance  = !out_valid_q || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	// Link state.
	logic [3:0] retry_limit_q;
	phase_t     phase_q;
	logic [3:0] retry_q;
	logic [7:0] next_seq_q;
	logic [7:0] pend_seq_q;
	logic [3:0] pend_flags_q;
	logic [7:0] pend_byte_q;

	// Unpacked request fields.
	logic [2:0]  req_type;
	logic [7:0]  data_byte, rx_seq, rx_ack_num, rx_flags, rx_len, rx_data;
	logic [15:0] rx_checksum;
	logic        rx_frame_ok;

	assign req_type    = user_s1[2:0];
	assign data_byte   = data_s1[7:0];
	assign rx_seq      = data_s1[15:8];
	assign rx_ack_num  = data_s1[23:16];
	assign rx_flags    = data_s1[31:24];
	assign rx_len      = data_s1[39:32];
	assign rx_data     = data_s1[47:40];
	assign rx_checksum = data_s1[63:48];
	assign rx_frame_ok = data_s1[64];

	// Next state and the packet to transmit.
	phase_t     phase_d;
	logic [3:0] retry_d;
	logic [7:0] next_seq_d, pend_seq_d, pend_byte_d;
	logic [3:0] pend_flags_d;
	logic       send;
	logic [7:0] tx_seq, tx_ack, tx_data;
	logic [3:0] tx_flags;
	logic       tx_len;
	logic [15:0] tx_sum;
	logic [2:0] status;
	logic       waiting, rx_good, want_retry;
	logic [7:0] want_ack;

	always_comb begin
		phase_d      = phase_q;
		retry_d      = retry_q;
		next_seq_d   = next_seq_q;
		pend_seq_d   = pend_seq_q;
		pend_flags_d = pend_flags_q;
		pend_byte_d  = pend_byte_q;
		send         = 1'b0;
		tx_seq       = 8'd0;
		tx_ack       = 8'd0;
		tx_flags     = 4'd0;
		tx_len       = 1'b0;
		tx_data      = 8'd0;
		status       = ST_REJECTED;
		want_retry   = 1'b0;

		waiting  = (phase_q == PH_SYNW) || (phase_q == PH_DATAW) || (phase_q == PH_FINW);
		want_ack = pend_seq_q + 8'd1;
		rx_good  = rx_frame_ok &&
			(rx_checksum == hdr_csum(rx_seq, rx_ack_num, rx_flags, rx_len, rx_data));

		if (req_type == REQ_OPEN && phase_q == PH_IDLE) begin
			// SYN always carries sequence zero; the handshake ACK uses one.
			pend_seq_d   = 8'd0;
			pend_flags_d = FLG_SYN;
			pend_byte_d  = 8'd0;
			retry_d      = 4'd0;
			phase_d      = PH_SYNW;
			next_seq_d   = 8'd1;
			send         = 1'b1;
			tx_flags     = FLG_SYN;
			status       = ST_NEW;
		end else if (req_type == REQ_SEND && phase_q == PH_EST) begin
			pend_seq_d   = next_seq_q;
			pend_flags_d = FLG_DATA;
			pend_byte_d  = data_byte;
			retry_d      = 4'd0;
			phase_d      = PH_DATAW;
			send         = 1'b1;
			tx_seq       = next_seq_q;
			tx_flags     = FLG_DATA;
			tx_len       = 1'b1;
			tx_data      = data_byte;
			status       = ST_NEW;
		end else if (req_type == REQ_CLOSE && phase_q == PH_EST) begin
			pend_seq_d   = next_seq_q;
			pend_flags_d = FLG_FIN;
			pend_byte_d  = 8'd0;
			retry_d      = 4'd0;
			phase_d      = PH_FINW;
			send         = 1'b1;
			tx_seq       = next_seq_q;
			tx_flags     = FLG_FIN;
			status       = ST_NEW;
		end else if (req_type == REQ_TIMEOUT && waiting) begin
			want_retry = 1'b1;
		end else if (req_type == REQ_RECV && waiting) begin
			if (!rx_good) begin
				// Corrupt or foreign packets are ignored and cost no retry.
				status = ST_DROPPED;
			end else if (phase_q == PH_SYNW) begin
				if (rx_flags[0] && rx_flags[1] && rx_ack_num == 8'd1) begin
					send       = 1'b1;
					tx_seq     = 8'd1;
					tx_ack     = 8'd1;
					tx_flags   = FLG_ACK;
					next_seq_d = 8'd1;
					phase_d    = PH_EST;
					status     = ST_CONNECTED;
				end else begin
					want_retry = 1'b1;
				end
			end else if (rx_flags[1] && rx_ack_num == want_ack) begin
				next_seq_d = want_ack;
				if (phase_q == PH_DATAW) begin
					phase_d = PH_EST;
					status  = ST_ACKED;
				end else begin
					phase_d = PH_CLOSED;
					status  = ST_CLOSED;
				end
			end else begin
				// A valid reply that is not the awaited one acts as a timeout.
				want_retry = 1'b1;
			end
		end

		if (want_retry) begin
			if (retry_q < retry_limit_q) begin
				retry_d  = retry_q + 4'd1;
				send     = 1'b1;
				tx_seq   = pend_seq_q;
				tx_flags = pend_flags_q;
				tx_len   = (pend_flags_q == FLG_DATA);
				tx_data  = (pend_flags_q == FLG_DATA) ? pend_byte_q : 8'd0;
				status   = ST_RESENT;
			end else begin
				phase_d = PH_FAILED;
				status  = ST_GAVEUP;
			end
		end

		tx_sum = send ? hdr_csum(tx_seq, tx_ack, {4'd0, tx_flags}, {7'd0, tx_len}, tx_data)
			: 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_LIMIT_RESET;
		end else if (cfg_we) begin
			retry_limit_q <= cfg_wdata;
		end
	end

	// Control state of both pipeline stages and the link.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			phase_q      <= PH_IDLE;
			retry_q      <= 4'd0;
			next_seq_q   <= 8'd0;
			pend_seq_q   <= 8'd0;
			pend_flags_q <= 4'd0;
			pend_byte_q  <= 8'd0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				phase_q      <= phase_d;
				retry_q      <= retry_d;
				next_seq_q   <= next_seq_d;
				pend_seq_q   <= pend_seq_d;
				pend_flags_q <= pend_flags_d;
				pend_byte_q  <= pend_byte_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
			user_s1 <= s_tuser;
		end
		if (fire) begin
			out_data_q <= {phase_code(phase_d), tx_sum, tx_data, tx_len, tx_flags, tx_ack, tx_seq};
			out_user_q <= {status, send};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
